>>> sv/ffpa_pkg.sv
package ffpa_pkg;
  localparam int unsigned PoolLog2Bytes = 39;
  localparam int unsigned PageShift = 12;
  localparam int unsigned MaxSegments = 64;
  localparam int unsigned IdxW = $clog2(MaxSegments);
  localparam int unsigned CntW = $clog2(MaxSegments + 1);
  localparam logic [27:0] PoolPages = 28'(64'd1 << (PoolLog2Bytes - PageShift));
  localparam logic [31:0] EmptyTag = 32'h2020_2020;

  typedef enum logic [1:0] {
    CMD_RESERVE = 2'd0,
    CMD_FREE    = 2'd1,
    CMD_QUERY   = 2'd2,
    CMD_BAD     = 2'd3
  } cmd_e;

  typedef enum logic [1:0] {
    ST_OK      = 2'd0,
    ST_NOSPACE = 2'd1,
    ST_FULL    = 2'd2,
    ST_BADH    = 2'd3
  } status_e;

  typedef struct packed {
    logic [1:0]  cmd;
    logic [27:0] size_pages;
    logic [26:0] handle;
    logic [31:0] tag;
    logic [63:0] user_data;
  } req_t;

  typedef struct packed {
    logic [1:0]  status;
    logic [26:0] seg_handle;
    logic [51:0] address_page;
    logic [27:0] seg_pages;
    logic [63:0] seg_user_data;
  } rsp_t;

  typedef struct packed {
    logic [26:0] start;
    logic [27:0] size;
    logic        used;
    logic [31:0] tag;
    logic [63:0] user;
  } seg_t;

  // per-cycle operation broadcast to every cell
  typedef enum logic [2:0] {
    OP_HOLD  = 3'd0,
    OP_WRITE = 3'd1,
    OP_SPLIT = 3'd2,
    OP_SHR   = 3'd3,
    OP_SHL   = 3'd4
  } op_e;

  typedef struct packed {
    logic [2:0]      op;
    logic [IdxW-1:0] idx;
    seg_t            wdata;
    seg_t            split;
  } cell_ctl_t;
endpackage

>>> sv/ffpa_cell.sv
module ffpa_cell (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                reset_first_i,
  input  logic [ffpa_pkg::IdxW-1:0] my_idx_i,
  input  ffpa_pkg::cell_ctl_t ctl_i,
  input  ffpa_pkg::seg_t      left_i,
  input  ffpa_pkg::seg_t      right_i,
  input  logic                last_i,
  output ffpa_pkg::seg_t      seg_o
);
  import ffpa_pkg::*;
  seg_t seg_q, seg_d, clr;

  always_comb begin
    clr = '{start: '0, size: '0, used: 1'b0, tag: EmptyTag, user: '0};
    seg_d = seg_q;
    unique case (op_e'(ctl_i.op))
      OP_WRITE: if (my_idx_i == ctl_i.idx) seg_d = ctl_i.wdata;
      OP_SPLIT: begin
        if (my_idx_i == ctl_i.idx) seg_d = ctl_i.wdata;
        else if (my_idx_i == ctl_i.idx + 1'b1) seg_d = ctl_i.split;
        else if (my_idx_i > ctl_i.idx + 1'b1) seg_d = left_i;
      end
      OP_SHL: if (my_idx_i >= ctl_i.idx) seg_d = last_i ? clr : right_i;
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      seg_q <= '{start: '0, size: reset_first_i ? PoolPages : '0, used: 1'b0,
                 tag: EmptyTag, user: '0};
    end else begin
      seg_q <= seg_d;
    end
  end

  assign seg_o = seg_q;
endmodule

>>> sv/first_fit_page_range_allocator.sv
// sequence: an accepted start passes through search, decide and report before the result strobe
//   a free also passes the two merge states, and each merge with a neighbor adds a removal step
// a new command is accepted only while idle, busy stays high through the strobe
// the result strobe lasts one cycle, the receiver cannot stall
// reset: one free segment covers the whole pool, pool base is zero
module first_fit_page_range_allocator (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            start,
  output logic            busy,
  input  ffpa_pkg::req_t  req_i,
  output logic            done_o,
  output ffpa_pkg::rsp_t  rsp_o,
  input  logic            cfg_valid_i,
  output logic            cfg_ready_o,
  input  logic [51:0]     cfg_data_i
);
  import ffpa_pkg::*;

  typedef enum logic [5:0] {
    S_IDLE = 6'b000001, S_FIND = 6'b000010, S_DO = 6'b000100,
    S_M1 = 6'b001000, S_M2 = 6'b010000, S_OUT = 6'b100000
  } state_e;

  state_e    state_q, state_d;
  seg_t      segs [MaxSegments];
  cell_ctl_t ctl;
  cell_ctl_t ctl_eff;
  req_t      req_q;
  rsp_t      rsp_q, rsp_d;
  logic [51:0] base_q;
  logic [CntW-1:0] cnt_q, cnt_d;
  logic [IdxW-1:0] hit_q, hit_d;
  logic            found_q, found_d;
  logic [MaxSegments-1:0] match;
  // removal phases after each merge write
  logic            rm_q;
  logic            merge_wr;

  assign cfg_ready_o = 1'b1;
  assign busy = (state_q != S_IDLE);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) base_q <= '0;
    else if (cfg_valid_i) base_q <= cfg_data_i;
  end

  for (genvar g = 0; g < MaxSegments; g++) begin : g_cell
    ffpa_cell u_cell (
      .clk_i, .rst_ni,
      .reset_first_i(g == 0),
      .my_idx_i(IdxW'(g)),
      .ctl_i(ctl_eff),
      .left_i(segs[(g == 0) ? 0 : g - 1]),
      .right_i(segs[(g == MaxSegments - 1) ? g : g + 1]),
      .last_i((g == MaxSegments - 1) || (CntW'(g + 1) >= cnt_q)),
      .seg_o(segs[g])
    );
    assign match[g] = (CntW'(g) < cnt_q) &&
        ((req_q.cmd == CMD_RESERVE) ?
         (!segs[g].used && (segs[g].size >= req_q.size_pages)) :
         (segs[g].used && (segs[g].start == req_q.handle)));
  end

  always_comb begin
    found_d = 1'b0;
    hit_d = '0;
    for (int i = MaxSegments - 1; i >= 0; i--) begin
      if (match[i]) begin
        found_d = 1'b1;
        hit_d = IdxW'(i);
      end
    end
  end

  always_comb begin
    seg_t s, nb;
    s = segs[hit_q];
    nb = '0;
    state_d = state_q;
    cnt_d = cnt_q;
    rsp_d = rsp_q;
    ctl = '0;
    ctl.op = OP_HOLD;
    ctl.idx = hit_q;
    unique case (state_q)
      S_IDLE: if (start) state_d = S_FIND;
      S_FIND: state_d = S_DO;
      S_DO: begin
        rsp_d = '0;
        state_d = S_OUT;
        if (req_q.cmd == CMD_BAD) rsp_d.status = ST_BADH;
        else if (req_q.cmd == CMD_RESERVE &&
                 (req_q.size_pages == '0 || !found_q)) rsp_d.status = ST_NOSPACE;
        else if (req_q.cmd != CMD_RESERVE && !found_q) rsp_d.status = ST_BADH;
        else if (req_q.cmd == CMD_RESERVE && s.size != req_q.size_pages &&
                 cnt_q >= CntW'(MaxSegments)) rsp_d.status = ST_FULL;
        else begin
          rsp_d.seg_handle = s.start;
          rsp_d.address_page = base_q + 52'(s.start);
          rsp_d.seg_user_data = (req_q.cmd == CMD_RESERVE) ? req_q.user_data : s.user;
          rsp_d.seg_pages = (req_q.cmd == CMD_RESERVE) ? req_q.size_pages : s.size;
          ctl.wdata = s;
          if (req_q.cmd == CMD_RESERVE) begin
            ctl.wdata.used = 1'b1;
            ctl.wdata.tag = req_q.tag;
            ctl.wdata.user = req_q.user_data;
            ctl.wdata.size = req_q.size_pages;
            if (s.size != req_q.size_pages) begin
              ctl.op = OP_SPLIT;
              ctl.split = '{start: s.start + req_q.size_pages[26:0],
                             size: s.size - req_q.size_pages, used: 1'b0,
                             tag: EmptyTag, user: '0};
              cnt_d = cnt_q + 1'b1;
            end else ctl.op = OP_WRITE;
          end else if (req_q.cmd == CMD_FREE) begin
            ctl.op = OP_WRITE;
            ctl.wdata.used = 1'b0;
            ctl.wdata.tag = EmptyTag;
            state_d = S_M1;
          end
        end
      end
      S_M1: begin
        // merge a free successor into the freed segment
        state_d = S_M2;
        nb = segs[hit_q + 1'b1];
        if (CntW'(hit_q) + 1'b1 < cnt_q && !nb.used) begin
          ctl.op = OP_WRITE;
          ctl.wdata = s;
          ctl.wdata.size = s.size + nb.size;
        end
      end
      S_M2: begin
        // merge the freed segment into a free predecessor
        state_d = S_OUT;
        nb = segs[hit_q - 1'b1];
        if (hit_q != '0 && !nb.used) begin
          ctl.op = OP_WRITE;
          ctl.idx = hit_q - 1'b1;
          ctl.wdata = nb;
          ctl.wdata.size = nb.size + s.size;
        end
      end
      S_OUT: state_d = S_IDLE;
      default: state_d = S_IDLE;
    endcase
  end

  assign merge_wr = (state_q == S_M1 || state_q == S_M2) && (ctl.op == OP_WRITE);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      cnt_q <= CntW'(1);
      found_q <= 1'b0;
      hit_q <= '0;
      rm_q <= 1'b0;
    end else if (rm_q) begin
      rm_q <= 1'b0;
      cnt_q <= cnt_q - 1'b1;
    end else begin
      state_q <= state_d;
      cnt_q <= cnt_d;
      rm_q <= merge_wr;
      if (state_q == S_FIND) begin
        found_q <= found_d;
        hit_q <= hit_d;
      end else if (state_q == S_M2 && merge_wr) begin
        hit_q <= hit_q - 1'b1;
      end
    end
  end

  always_comb begin
    ctl_eff = ctl;
    if (rm_q) begin
      ctl_eff = '0;
      ctl_eff.op = OP_SHL;
      ctl_eff.idx = hit_q + 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (start && !busy) req_q <= req_i;
    if (state_q == S_DO) rsp_q <= rsp_d;
  end

  assign done_o = (state_q == S_OUT) && !rm_q;
  assign rsp_o = rsp_q;
endmodule
